>>> src/tdpt_pkg.sv
// Package: microcode types, step labels and control store for the prime test core.
package tdpt_pkg;

  // Step counter width and program labels
  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE      = 4'd0;
  localparam step_t STEP_CHK_LE1   = 4'd1;
  localparam step_t STEP_CHK_LT4   = 4'd2;
  localparam step_t STEP_CHK_EVEN  = 4'd3;
  localparam step_t STEP_INIT_D    = 4'd4;
  localparam step_t STEP_DIV_START = 4'd5;
  localparam step_t STEP_DIV_LOOP  = 4'd6;
  localparam step_t STEP_TEST_Q    = 4'd7;
  localparam step_t STEP_TEST_REM  = 4'd8;
  localparam step_t STEP_NEXT_D    = 4'd9;
  localparam step_t STEP_PRIME     = 4'd10;
  localparam step_t STEP_COMP      = 4'd11;
  localparam step_t STEP_NEITHER   = 4'd12;
  localparam step_t STEP_WAIT_OUT  = 4'd13;
  localparam step_t STEP_POST      = 4'd14;
  localparam step_t STEP_LAST      = STEP_POST;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT_D,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_D_ADD2,
    OP_SET_FLAGS,
    OP_POST
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_N_LE_1,
    C_N_LT_4,
    C_N_EVEN,
    C_DIV_BUSY,
    C_D_GT_Q,
    C_REM_ZERO,
    C_OUT_BUSY
  } cond_t;

  // One control word
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  set_prime;
    logic  set_comp;
  } ucode_t;

  // Control from sequencer to divider
  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

  // Control store
  function automatic ucode_t ucode_rom(step_t pc);
    ucode_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: STEP_IDLE, set_prime: 1'b0, set_comp: 1'b0};
    unique case (pc)
      STEP_IDLE:      w = '{OP_LOAD,      C_NO_INPUT, STEP_IDLE,     1'b0, 1'b0};
      STEP_CHK_LE1:   w = '{OP_NONE,      C_N_LE_1,   STEP_NEITHER,  1'b0, 1'b0};
      STEP_CHK_LT4:   w = '{OP_NONE,      C_N_LT_4,   STEP_PRIME,    1'b0, 1'b0};
      STEP_CHK_EVEN:  w = '{OP_NONE,      C_N_EVEN,   STEP_COMP,     1'b0, 1'b0};
      STEP_INIT_D:    w = '{OP_INIT_D,    C_NEVER,    STEP_IDLE,     1'b0, 1'b0};
      STEP_DIV_START: w = '{OP_DIV_START, C_NEVER,    STEP_IDLE,     1'b0, 1'b0};
      STEP_DIV_LOOP:  w = '{OP_DIV_STEP,  C_DIV_BUSY, STEP_DIV_LOOP, 1'b0, 1'b0};
      STEP_TEST_Q:    w = '{OP_NONE,      C_D_GT_Q,   STEP_PRIME,    1'b0, 1'b0};
      STEP_TEST_REM:  w = '{OP_NONE,      C_REM_ZERO, STEP_COMP,     1'b0, 1'b0};
      STEP_NEXT_D:    w = '{OP_D_ADD2,    C_ALWAYS,   STEP_DIV_START, 1'b0, 1'b0};
      STEP_PRIME:     w = '{OP_SET_FLAGS, C_ALWAYS,   STEP_WAIT_OUT, 1'b1, 1'b0};
      STEP_COMP:      w = '{OP_SET_FLAGS, C_ALWAYS,   STEP_WAIT_OUT, 1'b0, 1'b1};
      STEP_NEITHER:   w = '{OP_SET_FLAGS, C_NEVER,    STEP_IDLE,     1'b0, 1'b0};
      STEP_WAIT_OUT:  w = '{OP_NONE,      C_OUT_BUSY, STEP_WAIT_OUT, 1'b0, 1'b0};
      STEP_POST:      w = '{OP_POST,      C_ALWAYS,   STEP_IDLE,     1'b0, 1'b0};
      default:        w = '{OP_NONE,      C_ALWAYS,   STEP_IDLE,     1'b0, 1'b0};
    endcase
    return w;
  endfunction

endpackage

>>> src/trial_division_prime_test_core.sv
// Top level: microcoded trial-division primality tester.
//
//  channel | direction | ports                               | handshake
//  --------+-----------+-------------------------------------+----------------------
//  in      | input     | in_number[DATA_WIDTH-1:0] (signed)  | in_valid / in_ready
//  out     | output    | out_is_prime, out_is_composite      | out_valid / out_ready
//
// One transaction in at a time. Numbers of 3 or less and even numbers post their result
// without a division. Otherwise each odd divisor d = 3, 5, ... runs the one-bit-per-cycle
// divider (start and DATA_WIDTH-1 steps), two tests and the step of d, until d exceeds
// the quotient n/d; a prime n thus tries each odd d up to about sqrt(n).
// Reset returns the step counter to idle and drops any pending result.
// A waiting result does not block intake; a finished test stalls until the result is taken.
module trial_division_prime_test_core import tdpt_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_number,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_is_prime,
  output logic                         out_is_composite
);

  localparam int NW = DATA_WIDTH - 1;

  step_t           pc_r, pc_nxt;
  ucode_t          uc;
  logic            jump;
  logic [DATA_WIDTH-1:0] n_r;
  logic [NW-1:0]   mag;
  logic [NW-1:0]   d_r;
  logic            res_prime_r, res_comp_r;
  logic            out_valid_r, out_valid_nxt;
  logic            out_prime_r, out_comp_r;
  logic            in_acc, out_busy;
  div_ctrl_t       div_ctrl;
  logic [NW-1:0]   quo;
  logic            rem_zero, div_last;

  // Fetch the control word
  assign uc       = ucode_rom(pc_r);
  assign in_ready = (uc.op == OP_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign out_busy = out_valid_r && !out_ready;
  assign mag      = n_r[NW-1:0];

  // Evaluate the jump condition
  always_comb begin
    unique case (uc.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_INPUT: jump = !in_acc;
      C_N_LE_1:   jump = n_r[DATA_WIDTH-1] || (mag <= NW'(1));
      C_N_LT_4:   jump = (mag < NW'(4));
      C_N_EVEN:   jump = !n_r[0];
      C_DIV_BUSY: jump = !div_last;
      C_D_GT_Q:   jump = (d_r > quo);
      C_REM_ZERO: jump = rem_zero;
      C_OUT_BUSY: jump = out_busy;
      default:    jump = 1'b1;
    endcase
  end

  assign pc_nxt = jump ? uc.target : pc_r + step_t'(1);

  // Drive the divider
  assign div_ctrl.start = (uc.op == OP_DIV_START);
  assign div_ctrl.step  = (uc.op == OP_DIV_STEP);

  tdpt_divider #(.NW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (mag),
    .divisor  (d_r),
    .quotient (quo),
    .rem_zero (rem_zero),
    .last     (div_last)
  );

  // Output register: drop on take, load on post
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (uc.op == OP_POST) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      n_r <= in_number;
    end
    if (uc.op == OP_INIT_D) begin
      d_r <= NW'(3);
    end else if (uc.op == OP_D_ADD2) begin
      d_r <= d_r + NW'(2);
    end
    if (uc.op == OP_SET_FLAGS) begin
      res_prime_r <= uc.set_prime;
      res_comp_r  <= uc.set_comp;
    end
    if (uc.op == OP_POST) begin
      out_prime_r <= res_prime_r;
      out_comp_r  <= res_comp_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_prime     = out_prime_r;
  assign out_is_composite = out_comp_r;

`ifndef SYNTHESIS
  // A result is never both prime and composite
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_prime && out_is_composite))
    else $error("result flags both set");

  // Intake closes once a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice without a test");

  // Step counter stays inside the program
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= STEP_LAST)
    else $error("step counter out of program");

  // Posting a result only happens when the output register is free
  a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
    (uc.op == OP_POST) |-> !out_busy)
    else $error("result posted over a pending one");
`endif

endmodule

>>> src/tdpt_divider.sv
// Restoring divider, one quotient bit per cycle while ctrl.step is high; gives quotient and zero-remainder flag.
module tdpt_divider import tdpt_pkg::*; #(
  parameter int NW = 31
) (
  input  logic          clk,
  input  logic          rst_n,
  input  div_ctrl_t     ctrl,
  input  logic [NW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          rem_zero,
  output logic          last
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [NW-1:0] sh_r,  sh_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW:0]   partial;
  logic [NW:0]   diff;
  logic          fits;

  // Bring down the next dividend bit and trial-subtract
  assign partial = {rem_r, sh_r[NW-1]};
  assign diff    = partial - {1'b0, divisor};
  assign fits    = ~diff[NW];

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    if (ctrl.start) begin
      rem_nxt = '0;
      quo_nxt = '0;
      sh_nxt  = dividend;
      cnt_nxt = CW'(NW);
    end else if (ctrl.step) begin
      rem_nxt = fits ? diff[NW-1:0] : partial[NW-1:0];
      quo_nxt = {quo_r[NW-2:0], fits};
      sh_nxt  = {sh_r[NW-2:0], 1'b0};
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // Hold the bit counter under reset; datapath needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    sh_r  <= sh_nxt;
  end

  assign quotient = quo_r;
  assign rem_zero = (rem_r == '0);
  assign last     = (cnt_r == CW'(1));

endmodule

>>> test/tb_trial_division_prime_test_core.sv
// Testbench for the trial-division prime test core: directed and random numbers, scoreboard check.
module tb_trial_division_prime_test_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DATA_WIDTH   = 32;
  localparam int          CLK_PERIOD   = 12;
  localparam int          RESET_CYCLES = 7;
  localparam int          RANDOM_ITEMS = 67;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 60;
  // The widest prime alone takes the longest test; the stall limit allows for it
  localparam int unsigned STALL_LIMIT  = 2_500_000;

  typedef logic signed [DATA_WIDTH-1:0] number_t;

  typedef struct {
    number_t number;
    bit      is_prime;
    bit      is_composite;
  } verdict_t;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  number_t in_number;
  logic    out_valid;
  logic    out_ready;
  logic    out_is_prime;
  logic    out_is_composite;

  verdict_t pending_verdicts[$];
  int       err_count     = 0;
  int       checked_count = 0;
  int       prime_seen    = 0;
  int       comp_seen     = 0;
  int       neither_seen  = 0;
  int       burst_left    = 0;
  bit       hold_request  = 1'b0;

  trial_division_prime_test_core #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_number        (in_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_prime     (out_is_prime),
    .out_is_composite (out_is_composite)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Work out the flags by trial division over odd divisors
  function automatic verdict_t classify_number(input number_t n);
    verdict_t          v;
    longint unsigned   mag;
    longint unsigned   d;
    bit                found;
    v.number       = n;
    v.is_prime     = 1'b0;
    v.is_composite = 1'b0;
    if (n > 1) begin
      mag   = longint'(n);
      found = (mag[0] == 1'b0) && (mag >= 4);
      for (d = 3; !found && (d * d <= mag); d += 2) begin
        if (mag % d == 0) found = 1'b1;
      end
      v.is_composite = found;
      v.is_prime     = !found;
    end
    return v;
  endfunction

  // Offer one number in bursts with random gaps; record its verdict on acceptance
  task automatic offer_number(input number_t n);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_number <= n;
    do @(posedge clk); while (!in_ready);
    pending_verdicts.push_back(classify_number(n));
  endtask

  // Small values, the no-divisor cases and squares of primes
  task automatic test_small_and_special();
    number_t picks[$];
    picks = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 15, 25, 49, 97, 100, 121, 63001, 65521};
    foreach (picks[i]) offer_number(picks[i]);
  endtask

  // Field extremes, the widest prime among them
  task automatic test_field_extremes();
    number_t picks[$];
    picks = '{32'sh8000_0000, -1, -7, 32'sh8000_0001, 32'sh7FFF_FFFE, 32'sh7FFF_FFFD,
              32'sh7FFF_FFFF};
    foreach (picks[i]) offer_number(picks[i]);
  endtask

  // Hold the result channel off while numbers keep coming, so intake backs up
  task automatic test_receiver_holdoff();
    hold_request = 1'b1;
    for (int i = 0; i < 8; i++) offer_number($urandom_range(0, 255));
    while (hold_request) @(posedge clk);
  endtask

  // Random mix: mostly cheap numbers, large ones forced to carry a small factor
  task automatic test_random_numbers();
    int          kind;
    int unsigned k;
    int unsigned r;
    number_t     n;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        n = $urandom_range(0, 4095);
      end else if (kind < 55) begin
        n = $urandom_range(4096, 65535);
      end else if (kind < 70) begin
        n = $urandom | 32'h8000_0000;
      end else if (kind < 85) begin
        k = $urandom_range(2, 63);
        r = $urandom_range(1, 32'h7FFF_FFFF / k);
        n = k * r;
      end else begin
        n = $urandom & 32'h7FFF_FFFE;
      end
      offer_number(n);
    end
  endtask

  // Result-side stalls: random segments of always-ready, half and quarter rate
  initial begin : receiver
    int seg_left;
    int mode;
    int held;
    seg_left  = 0;
    mode      = 0;
    held      = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        if (held < HOLD_CYCLES) begin
          out_ready <= 1'b0;
          held++;
        end else begin
          held         = 0;
          hold_request = 1'b0;
        end
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(20, 80);
          mode     = $urandom_range(0, 2);
        end
        seg_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest outstanding verdict
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: is_prime %0b, is_composite %0b",
               out_is_prime, out_is_composite);
        err_count++;
      end else begin
        want = pending_verdicts.pop_front();
        checked_count++;
        if (out_is_prime !== want.is_prime) begin
          $error("is_prime for %0d: expected %0b, actual %0b",
                 want.number, want.is_prime, out_is_prime);
          err_count++;
        end
        if (out_is_composite !== want.is_composite) begin
          $error("is_composite for %0d: expected %0b, actual %0b",
                 want.number, want.is_composite, out_is_composite);
          err_count++;
        end
        if (want.is_prime) prime_seen++;
        else if (want.is_composite) comp_seen++;
        else neither_seen++;
      end
    end
  end

  // Watchdog: abort when no transaction moves for too long
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb_trial_division_prime_test_core: errors");
        $finish;
      end
    end
  end

  // Sequence the tests, drain and report
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_number = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_small_and_special();
    test_receiver_holdoff();
    test_field_extremes();
    test_random_numbers();
    in_valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d results checked (%0d prime, %0d composite, %0d neither),",
             checked_count, prime_seen, comp_seen, neither_seen);
    $display("summary: field extremes incl. 2^31-1, a %0d-cycle result hold-off, random gaps",
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("tb_trial_division_prime_test_core: clean");
    end else begin
      $display("tb_trial_division_prime_test_core: errors");
    end
    $finish;
  end

endmodule
